// ===== rtl/rufh_pkg.sv =====
package rufh_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

    // Configuration register indexes (byte address = 4 * index)
    localparam int       APB_ADDR_W     = 4;
    localparam bit [1:0] REG_FRAME_GAP  = 2'd0;
    localparam bit [1:0] REG_SEND_GAP   = 2'd1;
    localparam bit [1:0] REG_LINK_UP    = 2'd2;

    localparam bit [7:0] FRAME_GAP_RST  = 8'd5;
    localparam bit [7:0] SEND_GAP_RST   = 8'd10;

    // Input item kinds
    localparam bit IN_KIND_BYTE = 1'b0;
    localparam bit IN_KIND_TICK = 1'b1;

    // Result item kinds
    localparam bit [1:0] OUT_KIND_PING   = 2'd0;
    localparam bit [1:0] OUT_KIND_CMD    = 2'd1;
    localparam bit [1:0] OUT_KIND_PERMIT = 2'd2;

    // Frame header codes
    localparam bit [7:0] HDR_SYNC     = 8'hCC;
    localparam bit [7:0] HDR_PING     = 8'h87;
    localparam bit [7:0] HDR_PING_SUB = 8'h03;
    localparam bit [7:0] HDR_CMD      = 8'h86;
    localparam bit [7:0] PING_REPLY   = 8'h88;

    localparam int PING_MIN_LEN  = 7;
    localparam int CMD_MIN_LEN   = 4;
    localparam int CMD_HDR_LEN   = 3;
    localparam int PING_LAST_STEP = 5;
    localparam int PING_RSSI_IDX = 6;

    localparam int IDLE_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_MARK,
        ST_PERMIT
    } state_t;

endpackage

// ===== rtl/rufh_ram.sv =====
module rufh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/radio_uplink_frame_handler_top.sv =====
// Channel   | Dir | Handshake                | Payload
// ----------+-----+--------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready     | tuser: kind; tdata: rx_byte, modem_busy,
//           |     |                          |   downlink_pending
// m_axis    | out | m_axis_tvalid/tready     | tuser: out_kind, empty_command;
//           |     |                          |   tdata: out_byte; tlast: last
// apb       | in  | psel/penable, pready = 1 | 0x0 frame_gap_ms, 0x4 send_gap_ms, 0x8 link_up
//
// A byte item or a tick with no result leaves the handler in ST_IDLE. A tick that ends
// a frame walks the frame store through its single read port: each reply or payload
// item is read, then loaded into the output register; the empty command marker and a
// send permit are loaded directly. Input is held off (s_axis_tready low) meanwhile.
// Reset: no clearing pass; the store is only read below the byte count.
// Stalls: the output register holds while m_axis_tready is low; the walk waits on it.
module radio_uplink_frame_handler_top (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] modem_busy,
                                        // [9] downlink_pending, [15:10] zero
    input  logic        s_axis_tuser,   // [0] kind
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] empty_command
    output logic        m_axis_tlast,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rufh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rufh_pkg::*;

    // ---------------------------------------------------------------- state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic [7:0]         hdr0_reg, hdr0_next;
    logic [7:0]         hdr1_reg, hdr1_next;
    logic [7:0]         hdr2_reg, hdr2_next;    // also the command length
    logic [7:0]         step_reg, step_next;    // walk position in the reply/payload
    logic [1:0]         sel_kind_reg, sel_kind_next;
    logic               permit_reg, permit_next;

    logic [7:0]         frame_gap_reg;
    logic [7:0]         send_gap_reg;
    logic               link_up_reg;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [1:0]         out_kind_reg;
    logic               out_empty_reg;
    logic               out_last_reg;

    // ----------------------------------------------------------- input side
    logic               s_fire;
    logic               in_kind;
    logic [7:0]         rx_byte;
    logic               modem_busy;
    logic               downlink_pending;

    assign in_kind          = s_axis_tuser;
    assign rx_byte          = s_axis_tdata[7:0];
    assign modem_busy       = s_axis_tdata[8];
    assign downlink_pending = s_axis_tdata[9];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------- frame store RAM
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    rufh_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------ tick evaluation
    logic               byte_in;
    logic               tick_in;
    logic               store_full;
    logic [IDLE_W-1:0]  elapsed;
    logic               frame_done;
    logic               ping_hit;
    logic               cmd_hit;
    logic               permit_now;
    logic               seq_last;
    logic               out_free;

    assign byte_in    = s_fire && (in_kind == IN_KIND_BYTE);
    assign tick_in    = s_fire && (in_kind == IN_KIND_TICK);
    assign store_full = (count_reg == CNT_W'(FRAME_DEPTH));

    // busy clears the count, else it advances and saturates
    assign elapsed = modem_busy ? '0 :
                     (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + IDLE_W'(1);

    assign frame_done = (count_reg != '0) && (elapsed > IDLE_W'(frame_gap_reg));
    assign ping_hit   = frame_done && (count_reg >= CNT_W'(PING_MIN_LEN)) &&
                        (hdr0_reg == HDR_SYNC) && (hdr1_reg == HDR_PING) &&
                        (hdr2_reg == HDR_PING_SUB);
    // length check in 10 bits so count and len + 3 never wrap
    assign cmd_hit    = frame_done && (count_reg >= CNT_W'(CMD_MIN_LEN)) &&
                        (hdr0_reg == HDR_SYNC) && (hdr1_reg == HDR_CMD) &&
                        (10'(count_reg) >= 10'(hdr2_reg) + 10'(CMD_HDR_LEN));
    assign permit_now = link_up_reg && downlink_pending &&
                        (elapsed > IDLE_W'(send_gap_reg));

    assign seq_last = (sel_kind_reg == OUT_KIND_PING) ?
                      (step_reg == 8'(PING_LAST_STEP)) :
                      (8'(step_reg + 8'd1) == hdr2_reg);

    assign out_free = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_in)
                begin
                    if (ping_hit || (cmd_hit && hdr2_reg != 8'd0))
                    begin
                        state_next = ST_READ;
                    end
                    else if (cmd_hit)
                    begin
                        state_next = ST_MARK;
                    end
                    else if (permit_now)
                    begin
                        state_next = ST_PERMIT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (!seq_last)
                    begin
                        state_next = ST_READ;
                    end
                    else if (permit_reg)
                    begin
                        state_next = ST_PERMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    state_next = permit_reg ? ST_PERMIT : ST_IDLE;
                end
            end
            ST_PERMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------- outputs
    logic               out_load;
    logic [7:0]         out_byte_next;
    logic [1:0]         out_kind_next;
    logic               out_empty_next;
    logic               out_last_next;

    always_comb
    begin
        ram_we         = byte_in && !store_full;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_re         = 1'b0;
        ram_raddr      = '0;
        out_load       = 1'b0;
        out_byte_next  = 8'd0;
        out_kind_next  = OUT_KIND_PERMIT;
        out_empty_next = 1'b0;
        out_last_next  = 1'b0;
        case (state_reg)
            ST_READ:
            begin
                ram_re = 1'b1;
                if (sel_kind_reg == OUT_KIND_PING)
                begin
                    // reply is bytes 0..4, then the RSSI byte in place of byte 5
                    ram_raddr = (step_reg < 8'(PING_LAST_STEP)) ?
                                step_reg[ADDR_W-1:0] : ADDR_W'(PING_RSSI_IDX);
                end
                else
                begin
                    ram_raddr = ADDR_W'(step_reg + 8'(CMD_HDR_LEN));
                end
            end
            ST_EMIT:
            begin
                out_load      = out_free;
                out_kind_next = sel_kind_reg;
                out_last_next = seq_last;
                out_byte_next = (sel_kind_reg == OUT_KIND_PING && step_reg == 8'd1) ?
                                PING_REPLY : ram_rdata;
            end
            ST_MARK:
            begin
                out_load       = out_free;
                out_kind_next  = OUT_KIND_CMD;
                out_empty_next = 1'b1;
                out_last_next  = 1'b1;
            end
            ST_PERMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------ datapath updates
    always_comb
    begin
        count_next    = count_reg;
        idle_next     = idle_reg;
        hdr0_next     = hdr0_reg;
        hdr1_next     = hdr1_reg;
        hdr2_next     = hdr2_reg;
        step_next     = step_reg;
        sel_kind_next = sel_kind_reg;
        permit_next   = permit_reg;

        if (byte_in)
        begin
            idle_next = '0;
            if (!store_full)
            begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(0))
                begin
                    hdr0_next = rx_byte;
                end
                if (count_reg == CNT_W'(1))
                begin
                    hdr1_next = rx_byte;
                end
                if (count_reg == CNT_W'(2))
                begin
                    hdr2_next = rx_byte;
                end
            end
        end

        if (tick_in)
        begin
            permit_next   = permit_now;
            step_next     = 8'd0;
            sel_kind_next = ping_hit ? OUT_KIND_PING : OUT_KIND_CMD;
            // a finished frame or a granted send restarts the idle count
            idle_next     = (frame_done || permit_now) ? '0 : elapsed;
            if (frame_done)
            begin
                count_next = '0;
            end
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            step_next = step_reg + 8'd1;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idle_reg      <= '0;
            permit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            permit_reg    <= permit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr0_reg     <= hdr0_next;
        hdr1_reg     <= hdr1_next;
        hdr2_reg     <= hdr2_next;
        step_reg     <= step_next;
        sel_kind_reg <= sel_kind_next;
        if (out_load)
        begin
            out_byte_reg  <= out_byte_next;
            out_kind_reg  <= out_kind_next;
            out_empty_reg <= out_empty_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_empty_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------- config port
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_gap_reg <= FRAME_GAP_RST;
            send_gap_reg  <= SEND_GAP_RST;
            link_up_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_GAP: frame_gap_reg <= pwdata[7:0];
                REG_SEND_GAP:  send_gap_reg  <= pwdata[7:0];
                REG_LINK_UP:   link_up_reg   <= pwdata[0];
                default:       link_up_reg   <= link_up_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_GAP: prdata = {24'd0, frame_gap_reg};
            REG_SEND_GAP:  prdata = {24'd0, send_gap_reg};
            REG_LINK_UP:   prdata = {31'd0, link_up_reg};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/rufh_checker.sv =====
module rufh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import rufh_pkg::*;

    // held result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // a permit carries no byte, no marker and no last flag
    a_permit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == OUT_KIND_PERMIT |->
            m_axis_tdata == 8'd0 && !m_axis_tuser[2] && !m_axis_tlast)
        else $error("malformed send permit");

    // empty command marker is a lone, zero, last command item
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1:0] == OUT_KIND_CMD && m_axis_tdata == 8'd0 && m_axis_tlast)
        else $error("malformed empty command marker");

    // a received byte never starts a result
    a_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == IN_KIND_BYTE |=>
            !$rose(m_axis_tvalid))
        else $error("result appeared after a received byte");

endmodule

bind radio_uplink_frame_handler_top rufh_checker u_rufh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
